FILE: rtl/core/indexed_binary_min_heap_unit_assert.svh
// ---------------------------------------------------------------------------
// Assertion macros for the indexed binary min-heap unit
// Clocked on clk, quiet while rst_n is low.
// ---------------------------------------------------------------------------
`ifndef INDEXED_BINARY_MIN_HEAP_UNIT_ASSERT_SVH
`define INDEXED_BINARY_MIN_HEAP_UNIT_ASSERT_SVH

// Same-cycle implication
`define IMBH_ASSERT_IMP(name, ante, cons, msg) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication
`define IMBH_ASSERT_NXT(name, ante, cons, msg) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

FILE: rtl/core/imbh_pkg.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// imbh_pkg
// Shared widths, defaults and codes of the indexed binary min-heap unit.
// ---------------------------------------------------------------------------
package imbh_pkg;

    // Fixed field widths
    localparam int OP_W        = 2;
    localparam int ID_W        = 10;
    localparam int ID_SPACE    = 1024;
    localparam int PRIO_IN_W   = 32;
    localparam int STATUS_W    = 3;
    localparam int COUNT_OUT_W = 11;
    localparam int WIDE_W      = 64;

    localparam logic [ID_W-1:0] ID_LAST = ID_W'(ID_SPACE - 1);

    // Defaults of the top-level parameters
    localparam int CAPACITY_DEF      = 1024;
    localparam int PRIORITY_BITS_DEF = 32;

    typedef enum logic [OP_W-1:0] {
        OP_INSERT   = 2'd0,
        OP_EXTRACT  = 2'd1,
        OP_DECREASE = 2'd2,
        OP_NOP      = 2'd3
    } op_t;

    typedef enum logic [STATUS_W-1:0] {
        ST_OK           = 3'd0,
        ST_EMPTY        = 3'd1,
        ST_ABSENT       = 3'd2,
        ST_FULL         = 3'd3,
        ST_PRESENT      = 3'd4,
        ST_NOT_DECREASE = 3'd5
    } status_t;

endpackage

FILE: rtl/core/indexed_binary_min_heap_unit.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// indexed_binary_min_heap_unit
// Indexed binary min-heap of (priority, id) pairs with an id-to-slot map.
// ---------------------------------------------------------------------------
// Raise start with a command while busy is low; the beat is taken on that
// edge. Each command returns exactly one result beat: done is high for one
// cycle with result_id, result_priority, status and entry_count_out valid,
// and the receiver cannot hold it off, so sample it then. A new command may
// be given in the same cycle as done. Sift steps go through the heap memory
// one tree level at a time, each level a read state and a compare state.
// After reset the position map is swept clear, with busy high, before the
// first command is taken.
// ---------------------------------------------------------------------------
module indexed_binary_min_heap_unit #(
    parameter int CAPACITY      = imbh_pkg::CAPACITY_DEF,
    parameter int PRIORITY_BITS = imbh_pkg::PRIORITY_BITS_DEF
) (
    input  logic                                  clk,
    input  logic                                  rst_n,
    input  logic                                  start,
    input  logic [imbh_pkg::OP_W-1:0]             operation,
    input  logic [imbh_pkg::ID_W-1:0]             item_id,
    input  logic signed [imbh_pkg::PRIO_IN_W-1:0] priority_req,
    output logic                                  busy,
    output logic                                  done,
    output logic [imbh_pkg::ID_W-1:0]             result_id,
    output logic signed [imbh_pkg::PRIO_IN_W-1:0] result_priority,
    output logic [imbh_pkg::STATUS_W-1:0]         status,
    output logic [imbh_pkg::COUNT_OUT_W-1:0]      entry_count_out
);

    localparam int SLOT_W = $clog2(CAPACITY);
    localparam int WORD_W = imbh_pkg::ID_W + PRIORITY_BITS;

    logic                          heap_we;
    logic [SLOT_W-1:0]             heap_waddr;
    logic [WORD_W-1:0]             heap_wdata;
    logic [SLOT_W-1:0]             heap_raddr_a;
    logic [SLOT_W-1:0]             heap_raddr_b;
    logic [WORD_W-1:0]             heap_rdata_a;
    logic [WORD_W-1:0]             heap_rdata_b;
    logic                          pos_we;
    logic [imbh_pkg::ID_W-1:0]     pos_waddr;
    logic [SLOT_W:0]               pos_wdata;
    logic [imbh_pkg::ID_W-1:0]     pos_raddr;
    logic [SLOT_W:0]               pos_rdata;

    // Sequencer
    imbh_ctrl #(
        .CAPACITY      (CAPACITY),
        .PRIORITY_BITS (PRIORITY_BITS)
    ) u_ctrl (
        .clk             (clk),
        .rst_n           (rst_n),
        .start           (start),
        .operation       (operation),
        .item_id         (item_id),
        .priority_req    (priority_req),
        .busy            (busy),
        .done            (done),
        .result_id       (result_id),
        .result_priority (result_priority),
        .status          (status),
        .entry_count_out (entry_count_out),
        .heap_we         (heap_we),
        .heap_waddr      (heap_waddr),
        .heap_wdata      (heap_wdata),
        .heap_raddr_a    (heap_raddr_a),
        .heap_raddr_b    (heap_raddr_b),
        .heap_rdata_a    (heap_rdata_a),
        .heap_rdata_b    (heap_rdata_b),
        .pos_we          (pos_we),
        .pos_waddr       (pos_waddr),
        .pos_wdata       (pos_wdata),
        .pos_raddr       (pos_raddr),
        .pos_rdata       (pos_rdata)
    );

    // Heap slots
    imbh_heap_ram #(
        .DEPTH (CAPACITY),
        .WIDTH (WORD_W)
    ) u_heap_ram (
        .clk     (clk),
        .we      (heap_we),
        .waddr   (heap_waddr),
        .wdata   (heap_wdata),
        .raddr_a (heap_raddr_a),
        .raddr_b (heap_raddr_b),
        .rdata_a (heap_rdata_a),
        .rdata_b (heap_rdata_b)
    );

    // Id-to-slot map
    imbh_pos_ram #(
        .DEPTH (imbh_pkg::ID_SPACE),
        .WIDTH (SLOT_W + 1)
    ) u_pos_ram (
        .clk   (clk),
        .we    (pos_we),
        .waddr (pos_waddr),
        .wdata (pos_wdata),
        .raddr (pos_raddr),
        .rdata (pos_rdata)
    );

endmodule

FILE: rtl/core/imbh_heap_ram.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// imbh_heap_ram
// Heap slot memory: one write port, two registered read ports.
// ---------------------------------------------------------------------------
module imbh_heap_ram #(
    parameter int DEPTH = imbh_pkg::CAPACITY_DEF,
    parameter int WIDTH = imbh_pkg::ID_W + imbh_pkg::PRIORITY_BITS_DEF
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr_a,
    input  logic [$clog2(DEPTH)-1:0] raddr_b,
    output logic [WIDTH-1:0]         rdata_a,
    output logic [WIDTH-1:0]         rdata_b
);

    logic [WIDTH-1:0] mem [DEPTH];

    // Write one slot, read two
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata_a <= mem[raddr_a];
        rdata_b <= mem[raddr_b];
    end

endmodule

FILE: rtl/core/imbh_pos_ram.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// imbh_pos_ram
// Position map memory: present flag and heap slot for every id.
// ---------------------------------------------------------------------------
module imbh_pos_ram #(
    parameter int DEPTH = imbh_pkg::ID_SPACE,
    parameter int WIDTH = $clog2(imbh_pkg::CAPACITY_DEF) + 1
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    // Write one entry, read one
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

FILE: rtl/core/imbh_ctrl.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// imbh_ctrl
// Sequencer: checks, sift up and sift down over the two memories.
// ---------------------------------------------------------------------------
module imbh_ctrl #(
    parameter int CAPACITY      = imbh_pkg::CAPACITY_DEF,
    parameter int PRIORITY_BITS = imbh_pkg::PRIORITY_BITS_DEF
) (
    input  logic                                           clk,
    input  logic                                           rst_n,
    // command side
    input  logic                                           start,
    input  logic [imbh_pkg::OP_W-1:0]                      operation,
    input  logic [imbh_pkg::ID_W-1:0]                      item_id,
    input  logic signed [imbh_pkg::PRIO_IN_W-1:0]          priority_req,
    output logic                                           busy,
    // result side
    output logic                                           done,
    output logic [imbh_pkg::ID_W-1:0]                      result_id,
    output logic signed [imbh_pkg::PRIO_IN_W-1:0]          result_priority,
    output logic [imbh_pkg::STATUS_W-1:0]                  status,
    output logic [imbh_pkg::COUNT_OUT_W-1:0]               entry_count_out,
    // heap memory
    output logic                                           heap_we,
    output logic [$clog2(CAPACITY)-1:0]                    heap_waddr,
    output logic [imbh_pkg::ID_W+PRIORITY_BITS-1:0]        heap_wdata,
    output logic [$clog2(CAPACITY)-1:0]                    heap_raddr_a,
    output logic [$clog2(CAPACITY)-1:0]                    heap_raddr_b,
    input  logic [imbh_pkg::ID_W+PRIORITY_BITS-1:0]        heap_rdata_a,
    input  logic [imbh_pkg::ID_W+PRIORITY_BITS-1:0]        heap_rdata_b,
    // position map memory
    output logic                                           pos_we,
    output logic [imbh_pkg::ID_W-1:0]                      pos_waddr,
    output logic [$clog2(CAPACITY):0]                      pos_wdata,
    output logic [imbh_pkg::ID_W-1:0]                      pos_raddr,
    input  logic [$clog2(CAPACITY):0]                      pos_rdata
);

    localparam int SLOT_W  = $clog2(CAPACITY);
    localparam int CNT_W   = $clog2(CAPACITY + 1);
    localparam int CHILD_W = SLOT_W + 2;
    localparam int PB      = PRIORITY_BITS;
    localparam int ID_W    = imbh_pkg::ID_W;
    localparam int WIDE_W  = imbh_pkg::WIDE_W;
    localparam int CNTO_W  = imbh_pkg::COUNT_OUT_W;
    localparam int PIN_W   = imbh_pkg::PRIO_IN_W;

    typedef enum logic [10:0] {
        S_CLEAR    = 11'b000_0000_0001,
        S_IDLE     = 11'b000_0000_0010,
        S_INS_CHK  = 11'b000_0000_0100,
        S_DEC_CHK  = 11'b000_0000_1000,
        S_DEC_CMP  = 11'b000_0001_0000,
        S_EXT_ROOT = 11'b000_0010_0000,
        S_EXT_LAST = 11'b000_0100_0000,
        S_UP_RD    = 11'b000_1000_0000,
        S_UP_CMP   = 11'b001_0000_0000,
        S_DN_RD    = 11'b010_0000_0000,
        S_DN_CMP   = 11'b100_0000_0000
    } state_t;

    state_t                   state_reg, state_next;
    logic [ID_W-1:0]          clr_reg, clr_next;
    logic [CNT_W-1:0]         count_reg, count_next;
    logic [SLOT_W-1:0]        slot_reg, slot_next;
    logic [ID_W-1:0]          id_reg, id_next;
    logic signed [PB-1:0]     key_reg, key_next;
    logic                     done_reg, done_next;
    logic [ID_W-1:0]          res_id_reg, res_id_next;
    logic signed [PB-1:0]     res_prio_reg, res_prio_next;
    imbh_pkg::status_t        res_status_reg, res_status_next;
    logic [CNTO_W-1:0]        res_count_reg, res_count_next;

    logic signed [WIDE_W-1:0] req_wide;
    logic signed [WIDE_W-1:0] res_wide;
    logic signed [PB-1:0]     key_in;
    logic signed [PB-1:0]     rd_a_key;
    logic signed [PB-1:0]     rd_b_key;
    logic [ID_W-1:0]          rd_a_id;
    logic [ID_W-1:0]          rd_b_id;
    logic [SLOT_W-1:0]        parent_idx;
    logic [CHILD_W-1:0]       left_idx;
    logic [CHILD_W-1:0]       right_idx;
    logic [CHILD_W-1:0]       count_ext;
    logic                     pos_present;
    logic [SLOT_W-1:0]        pos_slot;

    logic                     finish;
    imbh_pkg::status_t        fin_status;
    logic                     take_left;
    logic                     take_right;
    logic signed [PB-1:0]     best_key;

    // Narrow the request to the stored priority width, widen the result back
    assign req_wide = WIDE_W'(priority_req);
    assign key_in   = req_wide[PB-1:0];
    assign res_wide = WIDE_W'(res_prio_reg);

    // Unpack memory words
    assign rd_a_key    = heap_rdata_a[PB-1:0];
    assign rd_a_id     = heap_rdata_a[PB+ID_W-1:PB];
    assign rd_b_key    = heap_rdata_b[PB-1:0];
    assign rd_b_id     = heap_rdata_b[PB+ID_W-1:PB];
    assign pos_present = pos_rdata[SLOT_W];
    assign pos_slot    = pos_rdata[SLOT_W-1:0];

    // Tree neighbors of the hole
    assign parent_idx = (slot_reg - 1'b1) >> 1;
    assign left_idx   = CHILD_W'({slot_reg, 1'b1});
    assign right_idx  = left_idx + 1'b1;
    assign count_ext  = CHILD_W'(count_reg);

    // Pick the smaller child, left wins a tie
    always_comb
    begin
        take_left  = 1'b0;
        take_right = 1'b0;
        best_key   = key_reg;
        if (rd_a_key < key_reg)
        begin
            take_left = 1'b1;
            best_key  = rd_a_key;
        end
        if ((right_idx < count_ext) && (rd_b_key < best_key))
        begin
            take_left  = 1'b0;
            take_right = 1'b1;
        end
    end

    // Sequencer
    always_comb
    begin
        state_next      = state_reg;
        clr_next        = clr_reg;
        count_next      = count_reg;
        slot_next       = slot_reg;
        id_next         = id_reg;
        key_next        = key_reg;
        done_next       = 1'b0;
        res_id_next     = res_id_reg;
        res_prio_next   = res_prio_reg;
        res_status_next = res_status_reg;
        res_count_next  = res_count_reg;
        finish          = 1'b0;
        fin_status      = imbh_pkg::ST_OK;

        heap_we      = 1'b0;
        heap_waddr   = slot_reg;
        heap_wdata   = {id_reg, key_reg};
        heap_raddr_a = '0;
        heap_raddr_b = '0;
        pos_we       = 1'b0;
        pos_waddr    = id_reg;
        pos_wdata    = {1'b1, slot_reg};
        pos_raddr    = item_id;

        case (state_reg)
            // Mark every id absent after reset
            S_CLEAR:
            begin
                pos_we    = 1'b1;
                pos_waddr = clr_reg;
                pos_wdata = '0;
                clr_next  = clr_reg + 1'b1;
                if (clr_reg == imbh_pkg::ID_LAST)
                begin
                    state_next = S_IDLE;
                end
            end

            // Take a command beat and start the lookups
            S_IDLE:
            begin
                if (start)
                begin
                    id_next       = item_id;
                    key_next      = key_in;
                    res_id_next   = item_id;
                    res_prio_next = key_in;
                    case (imbh_pkg::op_t'(operation))
                        imbh_pkg::OP_INSERT:
                        begin
                            state_next = S_INS_CHK;
                        end
                        imbh_pkg::OP_DECREASE:
                        begin
                            state_next = S_DEC_CHK;
                        end
                        imbh_pkg::OP_EXTRACT:
                        begin
                            if (count_reg == '0)
                            begin
                                res_id_next   = '0;
                                res_prio_next = '0;
                                finish        = 1'b1;
                                fin_status    = imbh_pkg::ST_EMPTY;
                            end
                            else
                            begin
                                state_next = S_EXT_ROOT;
                            end
                        end
                        default:
                        begin
                            finish = 1'b1;
                        end
                    endcase
                end
            end

            // Reject duplicates and a full heap, else open a hole at the end
            S_INS_CHK:
            begin
                if (pos_present)
                begin
                    finish     = 1'b1;
                    fin_status = imbh_pkg::ST_PRESENT;
                end
                else if (count_reg == CNT_W'(CAPACITY))
                begin
                    finish     = 1'b1;
                    fin_status = imbh_pkg::ST_FULL;
                end
                else
                begin
                    slot_next  = SLOT_W'(count_reg);
                    count_next = count_reg + 1'b1;
                    state_next = S_UP_RD;
                end
            end

            // Find the id's slot
            S_DEC_CHK:
            begin
                if (!pos_present)
                begin
                    finish     = 1'b1;
                    fin_status = imbh_pkg::ST_ABSENT;
                end
                else
                begin
                    slot_next    = pos_slot;
                    heap_raddr_a = pos_slot;
                    state_next   = S_DEC_CMP;
                end
            end

            // Accept only a strict decrease
            S_DEC_CMP:
            begin
                if (!(key_reg < rd_a_key))
                begin
                    finish     = 1'b1;
                    fin_status = imbh_pkg::ST_NOT_DECREASE;
                end
                else
                begin
                    state_next = S_UP_RD;
                end
            end

            // Report the root, drop its id, fetch the last entry
            S_EXT_ROOT:
            begin
                res_id_next   = rd_a_id;
                res_prio_next = rd_a_key;
                pos_we        = 1'b1;
                pos_waddr     = rd_a_id;
                pos_wdata     = '0;
                count_next    = count_reg - 1'b1;
                if (count_reg == CNT_W'(1))
                begin
                    finish = 1'b1;
                end
                else
                begin
                    heap_raddr_a = SLOT_W'(count_reg - 1'b1);
                    state_next   = S_EXT_LAST;
                end
            end

            // Last entry moves into the hole at the root
            S_EXT_LAST:
            begin
                id_next    = rd_a_id;
                key_next   = rd_a_key;
                slot_next  = '0;
                state_next = S_DN_RD;
            end

            // Sift up: fetch the parent, or settle at the root
            S_UP_RD:
            begin
                if (slot_reg == '0)
                begin
                    heap_we = 1'b1;
                    pos_we  = 1'b1;
                    finish  = 1'b1;
                end
                else
                begin
                    heap_raddr_a = parent_idx;
                    state_next   = S_UP_CMP;
                end
            end

            // Sift up: pull a larger parent down, or settle here
            S_UP_CMP:
            begin
                heap_we = 1'b1;
                pos_we  = 1'b1;
                if (rd_a_key > key_reg)
                begin
                    heap_wdata = heap_rdata_a;
                    pos_waddr  = rd_a_id;
                    slot_next  = parent_idx;
                    state_next = S_UP_RD;
                end
                else
                begin
                    finish = 1'b1;
                end
            end

            // Sift down: fetch both children, or settle at a leaf
            S_DN_RD:
            begin
                if (left_idx >= count_ext)
                begin
                    heap_we = 1'b1;
                    pos_we  = 1'b1;
                    finish  = 1'b1;
                end
                else
                begin
                    heap_raddr_a = left_idx[SLOT_W-1:0];
                    heap_raddr_b = right_idx[SLOT_W-1:0];
                    state_next   = S_DN_CMP;
                end
            end

            // Sift down: lift the smaller child, or settle here
            S_DN_CMP:
            begin
                heap_we = 1'b1;
                pos_we  = 1'b1;
                if (take_right)
                begin
                    heap_wdata = heap_rdata_b;
                    pos_waddr  = rd_b_id;
                    slot_next  = right_idx[SLOT_W-1:0];
                    state_next = S_DN_RD;
                end
                else if (take_left)
                begin
                    heap_wdata = heap_rdata_a;
                    pos_waddr  = rd_a_id;
                    slot_next  = left_idx[SLOT_W-1:0];
                    state_next = S_DN_RD;
                end
                else
                begin
                    finish = 1'b1;
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase

        // Close the item and show the result beat
        if (finish)
        begin
            state_next      = S_IDLE;
            done_next       = 1'b1;
            res_status_next = fin_status;
            res_count_next  = CNTO_W'(count_next);
        end
    end

    // Control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_CLEAR;
            clr_reg   <= '0;
            count_reg <= '0;
            done_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            clr_reg   <= clr_next;
            count_reg <= count_next;
            done_reg  <= done_next;
        end
    end

    // Payload
    always_ff @(posedge clk)
    begin
        slot_reg       <= slot_next;
        id_reg         <= id_next;
        key_reg        <= key_next;
        res_id_reg     <= res_id_next;
        res_prio_reg   <= res_prio_next;
        res_status_reg <= res_status_next;
        res_count_reg  <= res_count_next;
    end

    assign busy            = (state_reg != S_IDLE);
    assign done            = done_reg;
    assign result_id       = res_id_reg;
    assign result_priority = res_wide[PIN_W-1:0];
    assign status          = res_status_reg;
    assign entry_count_out = res_count_reg;

endmodule

FILE: rtl/core/imbh_checker.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// imbh_checker
// Port-level checks of the heap unit, bound to the top level.
// ---------------------------------------------------------------------------
`include "indexed_binary_min_heap_unit_assert.svh"

module imbh_checker #(
    parameter int CAPACITY = imbh_pkg::CAPACITY_DEF
) (
    input logic                                  clk,
    input logic                                  rst_n,
    input logic                                  start,
    input logic                                  busy,
    input logic                                  done,
    input logic [imbh_pkg::ID_W-1:0]             result_id,
    input logic signed [imbh_pkg::PRIO_IN_W-1:0] result_priority,
    input logic [imbh_pkg::STATUS_W-1:0]         status,
    input logic [imbh_pkg::COUNT_OUT_W-1:0]      entry_count_out
);

    logic answer_in_range;
    logic empty_beat;
    logic empty_pair_zero;

    assign answer_in_range = (status <= imbh_pkg::ST_NOT_DECREASE)
                             && (entry_count_out <= CAPACITY);
    assign empty_beat      = done && (status == imbh_pkg::ST_EMPTY);
    assign empty_pair_zero = (entry_count_out == '0) && (result_id == '0)
                             && (result_priority == '0);

    // A result beat closes the work, so the unit is free again
    `IMBH_ASSERT_IMP(a_done_not_busy, done, !busy, "result beat while busy")

    // An accepted beat is either in work or answered at once
    `IMBH_ASSERT_NXT(a_accept_moves, start && !busy, busy || done, "command beat lost")

    // Status is a known code and the count stays within capacity
    `IMBH_ASSERT_IMP(a_status_range, done, answer_in_range, "bad status or count")

    // An empty extract leaves an empty heap and a zero pair
    `IMBH_ASSERT_IMP(a_empty_clean, empty_beat, empty_pair_zero, "empty answer not clean")

endmodule

bind indexed_binary_min_heap_unit imbh_checker #(.CAPACITY(CAPACITY)) u_imbh_checker (.*);

FILE: tb/indexed_binary_min_heap_unit_test.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// indexed_binary_min_heap_unit_test
// Self-checking bench for the indexed binary min-heap unit. Each command beat
// is applied to a local copy of the heap and its id-to-slot map at the edge
// that accepts it; every done beat is checked field by field against the
// oldest outstanding answer. Directed tests cover the empty heap, priority
// extremes, ties, duplicate ids and rejected decreases. Random traffic then
// churns the heap, grows it to full capacity and works it down again.
// ---------------------------------------------------------------------------
module indexed_binary_min_heap_unit_test;
    import imbh_pkg::*;

    localparam int HEAP_DEPTH   = CAPACITY_DEF;
    localparam int PRIO_BITS    = PRIORITY_BITS_DEF;
    localparam int NARROW       = (PRIO_BITS < PRIO_IN_W) ? PRIO_IN_W - PRIO_BITS : 0;
    localparam int DRAIN_CYCLES = 40;
    localparam int DRAIN_LIMIT  = 2000;
    localparam int LIMIT_NS     = 2_000_000;
    localparam int PRINT_CAP    = 50;

    localparam logic signed [PRIO_IN_W-1:0] PRIO_MIN = 32'sh8000_0000;
    localparam logic signed [PRIO_IN_W-1:0] PRIO_MAX = 32'sh7fff_ffff;

    typedef struct packed {
        logic [ID_W-1:0]               id;
        logic signed [PRIO_IN_W-1:0]   prio;
        status_t                       st;
        logic [COUNT_OUT_W-1:0]        count;
    } heap_answer_t;

    logic                           clk;
    logic                           rst_n;
    logic                           start;
    logic [OP_W-1:0]                operation;
    logic [ID_W-1:0]                item_id;
    logic signed [PRIO_IN_W-1:0]    priority_req;
    logic                           busy;
    logic                           done;
    logic [ID_W-1:0]                result_id;
    logic signed [PRIO_IN_W-1:0]    result_priority;
    logic [STATUS_W-1:0]            status;
    logic [COUNT_OUT_W-1:0]         entry_count_out;

    // Local copy of the heap, its slot map and occupancy
    logic signed [PRIO_IN_W-1:0]    heap_prio [HEAP_DEPTH];
    logic [ID_W-1:0]                heap_id [HEAP_DEPTH];
    int                             slot_of [ID_SPACE];
    bit                             id_held [ID_SPACE];
    int                             held_count;

    heap_answer_t                   pending_answers [$];
    heap_answer_t                   expected_answer;

    int mismatches;
    int beats_sent;
    int results_seen;
    int peak_count;
    int sender_idle_pct;
    int status_tally [6];

    indexed_binary_min_heap_unit #(
        .CAPACITY      (HEAP_DEPTH),
        .PRIORITY_BITS (PRIO_BITS)
    ) uut (
        .clk             (clk),
        .rst_n           (rst_n),
        .start           (start),
        .operation       (operation),
        .item_id         (item_id),
        .priority_req    (priority_req),
        .busy            (busy),
        .done            (done),
        .result_id       (result_id),
        .result_priority (result_priority),
        .status          (status),
        .entry_count_out (entry_count_out)
    );

    initial
    begin
        clk = 1'b0;
        forever #1 clk = ~clk;
    end

    task automatic report_mismatch(string what);
        mismatches++;
        if (mismatches <= PRINT_CAP)
            $display("[%0t] mismatch: %s", $time, what);
    endtask

    // Swap two heap slots and keep the id map in step
    function automatic void swap_slots(int a, int b);
        logic signed [PRIO_IN_W-1:0] tp;
        logic [ID_W-1:0]             ti;
        tp = heap_prio[a];
        ti = heap_id[a];
        heap_prio[a] = heap_prio[b];
        heap_id[a] = heap_id[b];
        heap_prio[b] = tp;
        heap_id[b] = ti;
        slot_of[heap_id[a]] = a;
        slot_of[heap_id[b]] = b;
    endfunction

    // Climb while the parent is strictly greater; a tie stops the climb
    function automatic void sift_toward_root(int s);
        int p;
        while (s > 0)
        begin
            p = (s - 1) / 2;
            if (!(heap_prio[p] > heap_prio[s]))
                break;
            swap_slots(p, s);
            s = p;
        end
    endfunction

    // Sink toward the strictly smaller child, left first on a tie
    function automatic void sift_toward_leaves(int s);
        int least;
        int l;
        int r;
        while (1)
        begin
            least = s;
            l = 2 * s + 1;
            r = l + 1;
            if (l < held_count && heap_prio[l] < heap_prio[least])
                least = l;
            if (r < held_count && heap_prio[r] < heap_prio[least])
                least = r;
            if (least == s)
                break;
            swap_slots(s, least);
            s = least;
        end
    endfunction

    // Apply one command to the local heap and return the answer it gives
    function automatic heap_answer_t apply_command(op_t op, logic [ID_W-1:0] id,
                                                   logic signed [PRIO_IN_W-1:0] prio_in);
        heap_answer_t                ans;
        logic signed [PRIO_IN_W-1:0] prio;
        int                          last;
        prio = (prio_in <<< NARROW) >>> NARROW;
        ans.id = id;
        ans.prio = prio;
        ans.st = ST_OK;
        case (op)
            OP_INSERT:
            begin
                if (id_held[id])
                    ans.st = ST_PRESENT;
                else if (held_count >= HEAP_DEPTH)
                    ans.st = ST_FULL;
                else
                begin
                    heap_prio[held_count] = prio;
                    heap_id[held_count] = id;
                    slot_of[id] = held_count;
                    id_held[id] = 1'b1;
                    held_count++;
                    sift_toward_root(held_count - 1);
                end
            end
            OP_EXTRACT:
            begin
                if (held_count == 0)
                begin
                    ans.st = ST_EMPTY;
                    ans.id = '0;
                    ans.prio = '0;
                end
                else
                begin
                    ans.id = heap_id[0];
                    ans.prio = heap_prio[0];
                    id_held[heap_id[0]] = 1'b0;
                    last = held_count - 1;
                    held_count = last;
                    if (last > 0)
                    begin
                        heap_prio[0] = heap_prio[last];
                        heap_id[0] = heap_id[last];
                        slot_of[heap_id[0]] = 0;
                        sift_toward_leaves(0);
                    end
                end
            end
            OP_DECREASE:
            begin
                if (!id_held[id])
                    ans.st = ST_ABSENT;
                else if (!(prio < heap_prio[slot_of[id]]))
                    ans.st = ST_NOT_DECREASE;
                else
                begin
                    heap_prio[slot_of[id]] = prio;
                    sift_toward_root(slot_of[id]);
                end
            end
            default:
            begin
            end
        endcase
        ans.count = COUNT_OUT_W'(held_count);
        return ans;
    endfunction

    // Drive one command beat from a falling edge; leave start high on return
    task automatic send_beat(op_t op, logic [ID_W-1:0] id, logic signed [PRIO_IN_W-1:0] prio);
        int gap;
        if (sender_idle_pct > 0 && $urandom_range(0, 99) < sender_idle_pct)
        begin
            gap = ($urandom_range(0, 3) == 0) ? $urandom_range(8, 32) : $urandom_range(1, 4);
            start <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        operation <= op;
        item_id <= id;
        priority_req <= prio;
        start <= 1'b1;
        @(posedge clk);
        while (busy !== 1'b0)
            @(posedge clk);
        pending_answers.insert(pending_answers.size(), apply_command(op, id, prio));
        beats_sent++;
        if (held_count > peak_count)
            peak_count = held_count;
        @(negedge clk);
    endtask

    function automatic logic signed [PRIO_IN_W-1:0] pick_priority();
        case ($urandom_range(0, 9))
            0, 1, 2, 3: return PRIO_IN_W'($urandom);
            4, 5, 6:    return PRIO_IN_W'(int'($urandom_range(0, 16)) - 8);
            7:
            begin
                case ($urandom_range(0, 3))
                    0:       return PRIO_MIN;
                    1:       return PRIO_MAX;
                    2:       return -1;
                    default: return 0;
                endcase
            end
            default:    return PRIO_IN_W'(int'($urandom_range(0, 2000)) - 1000);
        endcase
    endfunction

    // Probe upward from a random id to the next one not held
    function automatic logic [ID_W-1:0] pick_free_id();
        logic [ID_W-1:0] id;
        id = ID_W'($urandom_range(0, ID_SPACE - 1));
        while (id_held[id])
            id = id + 1'b1;
        return id;
    endfunction

    // One random command: mostly well-formed, with duplicates, misses and no-ops
    task automatic send_random_item(int ins_w, int ext_w);
        int                          roll;
        int                          slot;
        longint                      delta;
        longint                      lowered;
        logic [ID_W-1:0]             id;
        logic signed [PRIO_IN_W-1:0] p;
        roll = $urandom_range(0, 99);
        if (roll < 2)
            send_beat(OP_NOP, ID_W'($urandom), PRIO_IN_W'($urandom));
        else if (roll < 2 + ins_w)
        begin
            if (held_count >= ID_SPACE || (held_count > 0 && $urandom_range(0, 99) < 4))
                id = heap_id[$urandom_range(0, held_count - 1)];
            else
                id = pick_free_id();
            send_beat(OP_INSERT, id, pick_priority());
        end
        else if (roll < 2 + ins_w + ext_w)
            send_beat(OP_EXTRACT, ID_W'($urandom), PRIO_IN_W'($urandom));
        else if (held_count > 0 && $urandom_range(0, 99) < 85)
        begin
            slot = $urandom_range(0, held_count - 1);
            id = heap_id[slot];
            if (heap_prio[slot] == PRIO_MIN)
                p = pick_priority();
            else
            begin
                case ($urandom_range(0, 9))
                    0, 1, 2, 3, 4: delta = $urandom_range(1, 4);
                    5, 6, 7:       delta = $urandom_range(1, 1000);
                    default:       delta = $urandom_range(1, 32'h7fff_ffff);
                endcase
                lowered = longint'(heap_prio[slot]) - delta;
                if (lowered < longint'(PRIO_MIN))
                    lowered = longint'(PRIO_MIN);
                p = lowered[PRIO_IN_W-1:0];
            end
            send_beat(OP_DECREASE, id, p);
        end
        else
            send_beat(OP_DECREASE, ID_W'($urandom), pick_priority());
    endtask

    // Empty heap: extract, decrease of a missing id and no-op codes
    task automatic test_empty_heap();
        send_beat(OP_EXTRACT, ID_LAST, PRIO_MAX);
        send_beat(OP_DECREASE, '0, PRIO_MIN);
        send_beat(OP_NOP, ID_LAST, PRIO_MIN);
        send_beat(OP_NOP, '0, -1);
    endtask

    // Priority extremes, a tie and duplicate ids
    task automatic test_insert_edges();
        send_beat(OP_INSERT, '0, PRIO_MIN);
        send_beat(OP_INSERT, ID_LAST, PRIO_MAX);
        send_beat(OP_INSERT, ID_W'(512), 0);
        send_beat(OP_INSERT, ID_W'(341), 0);
        send_beat(OP_INSERT, ID_W'(682), -1);
        send_beat(OP_INSERT, '0, 5);
        send_beat(OP_INSERT, ID_LAST, PRIO_MIN);
    endtask

    // Equal and higher priorities are refused; a tie with the root stays put
    task automatic test_decrease_edges();
        send_beat(OP_DECREASE, ID_LAST, PRIO_MAX);
        send_beat(OP_DECREASE, ID_W'(512), 1);
        send_beat(OP_DECREASE, ID_W'(341), 0);
        send_beat(OP_DECREASE, ID_LAST, PRIO_MIN);
        send_beat(OP_DECREASE, ID_W'(100), -5);
        send_beat(OP_DECREASE, ID_W'(682), -2);
    endtask

    // Pop everything in order, then once more on the empty heap
    task automatic test_drain_to_empty();
        while (held_count > 0)
            send_beat(OP_EXTRACT, ID_W'($urandom), PRIO_IN_W'($urandom));
        send_beat(OP_EXTRACT, ID_LAST, PRIO_MIN);
    endtask

    task automatic test_mixed_traffic();
        sender_idle_pct = 0;
        repeat (100) send_random_item(45, 30);
    endtask

    // Grow to full capacity, then poke the full heap
    task automatic test_fill_to_capacity();
        sender_idle_pct = 45;
        while (held_count < HEAP_DEPTH)
            send_random_item(94, 0);
        repeat (12) send_random_item(60, 0);
    endtask

    task automatic test_shrink_traffic();
        sender_idle_pct = 28;
        repeat (120) send_random_item(15, 70);
    endtask

    // Check each done beat against the oldest outstanding answer
    always @(posedge clk)
    begin
        if (rst_n === 1'b1 && done === 1'b1)
        begin
            results_seen++;
            if (pending_answers.size() == 0)
                report_mismatch("result beat with no command outstanding");
            else
            begin
                expected_answer = pending_answers.pop_front();
                status_tally[expected_answer.st]++;
                if (result_id !== expected_answer.id)
                    report_mismatch($sformatf("result_id %0d, want %0d",
                                              result_id, expected_answer.id));
                if (result_priority !== expected_answer.prio)
                    report_mismatch($sformatf("result_priority %0d, want %0d",
                                              result_priority, expected_answer.prio));
                if (status !== expected_answer.st)
                    report_mismatch($sformatf("status %0d, want %0d",
                                              status, expected_answer.st));
                if (entry_count_out !== expected_answer.count)
                    report_mismatch($sformatf("entry_count_out %0d, want %0d",
                                              entry_count_out, expected_answer.count));
            end
        end
    end

    initial
    begin
        #(LIMIT_NS);
        $display("[FAIL] regression broken");
        $finish;
    end

    initial
    begin
        int waited;
        rst_n = 1'b0;
        start = 1'b0;
        operation = OP_INSERT;
        item_id = '0;
        priority_req = '0;
        held_count = 0;
        mismatches = 0;
        beats_sent = 0;
        results_seen = 0;
        peak_count = 0;
        sender_idle_pct = 0;
        foreach (id_held[i])
        begin
            id_held[i] = 1'b0;
            slot_of[i] = 0;
        end
        foreach (status_tally[i])
            status_tally[i] = 0;
        repeat (5) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        test_empty_heap();
        test_insert_edges();
        test_decrease_edges();
        test_drain_to_empty();
        test_mixed_traffic();
        test_fill_to_capacity();
        test_shrink_traffic();
        start <= 1'b0;

        // Wait out the answers still in flight, then a quiet tail
        waited = 0;
        while (pending_answers.size() > 0 && waited < DRAIN_LIMIT)
        begin
            @(posedge clk);
            waited++;
        end
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (pending_answers.size() != 0)
            report_mismatch($sformatf("%0d answers never arrived", pending_answers.size()));

        $display("covered %0d command beats, %0d results checked, peak occupancy %0d of %0d",
                 beats_sent, results_seen, peak_count, HEAP_DEPTH);
        $display("status mix: ok %0d, empty %0d, absent %0d, full %0d, dup %0d, not lower %0d",
                 status_tally[ST_OK], status_tally[ST_EMPTY], status_tally[ST_ABSENT],
                 status_tally[ST_FULL], status_tally[ST_PRESENT],
                 status_tally[ST_NOT_DECREASE]);
        if (mismatches == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end

endmodule

FILE: filelist.f
+incdir+rtl/core
rtl/core/imbh_pkg.sv
rtl/core/imbh_heap_ram.sv
rtl/core/imbh_pos_ram.sv
rtl/core/imbh_ctrl.sv
rtl/core/indexed_binary_min_heap_unit.sv
rtl/core/imbh_checker.sv
tb/indexed_binary_min_heap_unit_test.sv
